>>> hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent implication check under clock and asynchronous reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication check.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> hdl/pr3d_pkg.sv
// Package with constants, types and the arctangent table of the rotation block.
package pr3d_pkg;
	localparam int CoordWidth  = 32;
	localparam int FracBits    = 16;
	localparam int CordicSteps = 18;
	localparam int CoefBits    = 30;
	localparam int CW          = 36;

	localparam logic [31:0] TurnPerRad = 32'd683565276;
	localparam logic [31:0] TurnPerDeg = 32'd11930465;
	localparam logic signed [CW-1:0] GainQ30 = 36'sd652032874;

	typedef logic signed [CoordWidth-1:0] coord_t;
	typedef logic signed [CW-1:0] coef_t;

	// One CORDIC vector as it travels down the row of cells.
	typedef struct packed {
		coef_t x;
		coef_t y;
		logic signed [32:0] z;
		logic [1:0] q;
	} cvec_t;

	typedef struct packed {
		coord_t point_x;
		coord_t point_y;
		coord_t point_z;
		coord_t origin_x;
		coord_t origin_y;
		coord_t origin_z;
		coord_t pitch_angle;
		coord_t yaw_angle;
		coord_t roll_angle;
	} in_item_t;

	typedef struct packed {
		coord_t rotated_x;
		coord_t rotated_y;
		coord_t rotated_z;
		logic saturated;
	} out_item_t;

	// Arctangent of 2^-i in turn units (2^32 per turn).
	function automatic logic signed [32:0] atan_turn(input int i);
		logic [31:0] t;
		case (i)
			0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
			3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
			6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
			9: t = 32'h00145F2F;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
			12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
			15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
			18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
			21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
			24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
			27: t = 32'h00000005; 28: t = 32'h00000003; 29: t = 32'h00000001;
			30: t = 32'h00000001;
			default: t = 32'h0;
		endcase
		return $signed({1'b0, t});
	endfunction

	// Q30 product rounded to nearest, ties up.
	function automatic coef_t qmul(input coef_t a, input coef_t b);
		logic signed [2*CW-1:0] p;
		p = a * b + (72'sd1 <<< (CoefBits - 1));
		return coef_t'(p >>> CoefBits);
	endfunction
endpackage

>>> hdl/pr3d_if.sv
// Valid/ready channel interface carrying one item.
interface pr3d_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hdl/pr3d_cell.sv
// One CORDIC micro-rotation cell for three angles at once.
module pr3d_cell import pr3d_pkg::*; (
	input  logic       clk,
	input  logic       en,
	input  logic [4:0] step,
	input  cvec_t      vin [3],
	output cvec_t      vout [3]
);
	cvec_t nxt [3];

	// Rotate toward zero residual angle.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			nxt[k].q = vin[k].q;
			if (!vin[k].z[32]) begin
				nxt[k].x = vin[k].x - (vin[k].y >>> step);
				nxt[k].y = vin[k].y + (vin[k].x >>> step);
				nxt[k].z = vin[k].z - atan_turn(int'(step));
			end else begin
				nxt[k].x = vin[k].x + (vin[k].y >>> step);
				nxt[k].y = vin[k].y - (vin[k].x >>> step);
				nxt[k].z = vin[k].z + atan_turn(int'(step));
			end
		end
	end

	// The cell register holds its vector while the pipeline is stalled.
	always_ff @(posedge clk) begin
		if (en) vout <= nxt;
	end
endmodule

>>> hdl/point_rotate_3d_euler.sv
// Top level of the yaw-pitch-roll point rotation pipeline.
// Fully pipelined: one item is accepted every cycle while the output is not stalled,
// and its result passes two phase stages, a row of 18 CORDIC cells, four matrix
// stages, two product-sum stages and the output register. The whole
// pipeline advances only when the output register is free or being taken,
// so backpressure stalls every stage together.
`include "assert_macros.svh"
module point_rotate_3d_euler import pr3d_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	pr3d_if.sink   in_ch,
	pr3d_if.source out_ch
);
	localparam int Lat = CordicSteps + 9;

	logic deg_q;
	logic adv;
	logic [Lat-1:0] vld_q;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) deg_q <= 1'b0;
		else if (cfg_we) deg_q <= cfg_wdata;
	end

	assign adv = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = adv;

	// Valid flags of all stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (adv) vld_q <= {vld_q[Lat-2:0], in_ch.valid};
	end
	assign out_ch.valid = vld_q[Lat-1];

	// Stage 1: angle times turn scale, and the difference vector.
	logic [63:0] prod_s1 [3];
	coord_t ang [3];
	logic signed [CoordWidth:0] d_s1 [3];
	coord_t o_s1 [3];
	always_comb begin
		ang[0] = in_ch.data.yaw_angle;
		ang[1] = in_ch.data.pitch_angle;
		ang[2] = in_ch.data.roll_angle;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++)
				prod_s1[k] <= 64'(64'($signed(ang[k])) * {32'd0, deg_q ? TurnPerDeg : TurnPerRad});
			d_s1[0] <= 33'(in_ch.data.point_x) - 33'(in_ch.data.origin_x);
			d_s1[1] <= 33'(in_ch.data.point_y) - 33'(in_ch.data.origin_y);
			d_s1[2] <= 33'(in_ch.data.point_z) - 33'(in_ch.data.origin_z);
			o_s1[0] <= in_ch.data.origin_x;
			o_s1[1] <= in_ch.data.origin_y;
			o_s1[2] <= in_ch.data.origin_z;
		end
	end

	// Stage 2: phase, quadrant and residual into the cell row.
	cvec_t row [CordicSteps+1][3];
	cvec_t st_s2 [3];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				logic [31:0] ph, r;
				logic [1:0] q;
				ph = 32'((prod_s1[k] + (64'd1 << (FracBits - 1))) >> FracBits);
				q = 2'((ph + 32'h20000000) >> 30);
				r = ph - {q, 30'd0};
				st_s2[k].q <= q;
				st_s2[k].z <= $signed({r[31], r});
				st_s2[k].x <= GainQ30;
				st_s2[k].y <= '0;
			end
		end
	end
	assign row[0] = st_s2;

	// Delay line for the vector and origin alongside the cells.
	localparam int DLen = CordicSteps + 5;
	logic signed [CoordWidth:0] dd_q [DLen][3];
	coord_t od_q [DLen+2][3];
	always_ff @(posedge clk) begin
		if (adv) begin
			dd_q[0] <= d_s1;
			od_q[0] <= o_s1;
			for (int i = 1; i < DLen; i++) dd_q[i] <= dd_q[i-1];
			for (int i = 1; i < DLen + 2; i++) od_q[i] <= od_q[i-1];
		end
	end

	// Row of CORDIC cells; each cell holds its register while the pipeline stalls.
	for (genvar g = 0; g < CordicSteps; g++) begin : g_cell
		pr3d_cell u_cell (.clk(clk), .en(adv), .step(5'(g)), .vin(row[g]), .vout(row[g+1]));
	end

	// Quadrant fix-up: c and s per angle.
	coef_t c_s3 [3], s_s3 [3];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				case (row[CordicSteps][k].q)
					2'd0: begin c_s3[k] <= row[CordicSteps][k].x; s_s3[k] <= row[CordicSteps][k].y; end
					2'd1: begin c_s3[k] <= -row[CordicSteps][k].y; s_s3[k] <= row[CordicSteps][k].x; end
					2'd2: begin c_s3[k] <= -row[CordicSteps][k].x; s_s3[k] <= -row[CordicSteps][k].y; end
					default: begin c_s3[k] <= row[CordicSteps][k].y; s_s3[k] <= -row[CordicSteps][k].x; end
				endcase
			end
		end
	end

	// Matrix stage A: first-level products.
	coef_t ca_a, sa_a, cb_a, sb_a, cc_a, sc_a, sbsc_a, sbcc_a;
	always_ff @(posedge clk) begin
		if (adv) begin
			ca_a <= c_s3[0]; sa_a <= s_s3[0];
			cb_a <= c_s3[1]; sb_a <= s_s3[1];
			cc_a <= c_s3[2]; sc_a <= s_s3[2];
			sbsc_a <= qmul(s_s3[1], s_s3[2]);
			sbcc_a <= qmul(s_s3[1], c_s3[2]);
		end
	end

	// Matrix stage B: all second-level products.
	coef_t p_b [14];
	always_ff @(posedge clk) begin
		if (adv) begin
			p_b[0] <= qmul(ca_a, cb_a);
			p_b[1] <= qmul(ca_a, sbsc_a);
			p_b[2] <= qmul(sa_a, cc_a);
			p_b[3] <= qmul(ca_a, sbcc_a);
			p_b[4] <= qmul(sa_a, sc_a);
			p_b[5] <= qmul(sa_a, cb_a);
			p_b[6] <= qmul(sa_a, sbsc_a);
			p_b[7] <= qmul(ca_a, cc_a);
			p_b[8] <= qmul(sa_a, sbcc_a);
			p_b[9] <= qmul(ca_a, sc_a);
			p_b[10] <= -sb_a;
			p_b[11] <= qmul(cb_a, sc_a);
			p_b[12] <= qmul(cb_a, cc_a);
			p_b[13] <= '0;
		end
	end

	// Matrix stage C: combine into nine entries.
	coef_t m_c [9];
	always_ff @(posedge clk) begin
		if (adv) begin
			m_c[0] <= p_b[0];
			m_c[1] <= p_b[1] - p_b[2];
			m_c[2] <= p_b[3] + p_b[4];
			m_c[3] <= p_b[5];
			m_c[4] <= p_b[6] + p_b[7];
			m_c[5] <= p_b[8] - p_b[9];
			m_c[6] <= p_b[10] + p_b[13];
			m_c[7] <= p_b[11];
			m_c[8] <= p_b[12];
		end
	end

	// Product stage: nine matrix-by-vector products, exact.
	localparam int PW = CW + CoordWidth + 1;
	logic signed [PW-1:0] mp_q [9];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++)
				for (int k = 0; k < 3; k++)
					mp_q[3*r+k] <= PW'(m_c[3*r+k]) * PW'(dd_q[DLen-1][k]);
		end
	end

	// Sum stage: row sums with rounding constant.
	logic signed [PW+1:0] sum_q [3];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++)
				sum_q[r] <= (PW+2)'(mp_q[3*r]) + (PW+2)'(mp_q[3*r+1]) + (PW+2)'(mp_q[3*r+2])
					+ ((PW+2)'(1) <<< (CoefBits - 1));
		end
	end

	// Coordinate limits at the width of the row sums.
	localparam logic signed [PW+1:0] VHi = (PW+2)'($signed({1'b0, {(CoordWidth-1){1'b1}}}));
	localparam logic signed [PW+1:0] VLo = (PW+2)'($signed({1'b1, {(CoordWidth-1){1'b0}}}));

	// Output stage: scale, add origin, saturate.
	out_item_t res;
	always_comb begin
		logic signed [PW+1:0] v [3];
		coord_t cl [3];
		logic sat;
		sat = 1'b0;
		for (int r = 0; r < 3; r++) begin
			v[r] = (sum_q[r] >>> CoefBits) + (PW+2)'(od_q[DLen+1][r]);
			if (v[r] > VHi) begin
				cl[r] = {1'b0, {(CoordWidth-1){1'b1}}}; sat = 1'b1;
			end else if (v[r] < VLo) begin
				cl[r] = {1'b1, {(CoordWidth-1){1'b0}}}; sat = 1'b1;
			end else begin
				cl[r] = coord_t'(v[r]);
			end
		end
		res.rotated_x = cl[0];
		res.rotated_y = cl[1];
		res.rotated_z = cl[2];
		res.saturated = sat;
	end

	out_item_t res_q;
	always_ff @(posedge clk) begin
		if (adv) res_q <= res;
	end
	assign out_ch.data = res_q;

	// Checks on the pipeline control.
	`ASSERT_NEXT(a_stall_holds, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(vld_q), "stall lost an item")
	`ASSERT_IMPL(a_ready_free, clk, arst_n, !out_ch.valid, in_ch.ready, "ready low with empty output")
	`ASSERT_NEXT(a_shift, clk, arst_n, in_ch.valid && in_ch.ready, vld_q[0], "accepted item not tracked")
endmodule

>>> dv/tb_point_rotate_3d_euler.sv
// Testbench for the yaw-pitch-roll point rotation pipeline, checked against its own predictor.
module tb_point_rotate_3d_euler;
	import pr3d_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		in_item_t  stim;
		bit        known;
		out_item_t res;
	} dir_row_t;

	localparam longint AtanTurn [0:31] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
		64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
		64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
		64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
		64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
		64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
		64'h00000001, 64'h00000000};

	localparam coord_t CMax = 32'sh7FFFFFFF;
	localparam coord_t CMin = 32'sh80000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;

	pr3d_if #(.T(in_item_t))  in_ch ();
	pr3d_if #(.T(out_item_t)) out_ch ();

	point_rotate_3d_euler dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_ch(in_ch), .out_ch(out_ch)
	);

	out_item_t rotated_q[$];
	bit        deg_mode = 1'b0;
	int        fails = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#3000000;
		$display("tb_point_rotate_3d_euler: FAIL");
		$finish;
	end

	// Q30 product rounded to nearest.
	function automatic longint q30_mul(input longint a, input longint b);
		return (a * b + (64'sd1 <<< 29)) >>> 30;
	endfunction

	// Sine and cosine of one angle through the quadrant split and CORDIC.
	function automatic void angle_trig(input coord_t raw, input bit deg,
			output longint cv, output longint sv);
		longint unsigned mult, prod;
		logic [31:0] phase, resid;
		logic [1:0]  quad;
		longint      z, x, y, nx;
		mult  = deg ? 64'(TurnPerDeg) : 64'(TurnPerRad);
		prod  = longint'(raw) * mult + (64'd1 << (FracBits - 1));
		phase = prod[FracBits +: 32];
		quad  = 2'((phase + 32'h20000000) >> 30);
		resid = phase - {quad, 30'b0};
		z     = longint'($signed(resid));
		x     = 652032874;
		y     = 0;
		for (int i = 0; i < CordicSteps; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y  = y + (x >>> i);
				z  = z - AtanTurn[i];
			end else begin
				nx = x + (y >>> i);
				y  = y - (x >>> i);
				z  = z + AtanTurn[i];
			end
			x = nx;
		end
		case (quad)
			2'd0: begin cv = x;  sv = y;  end
			2'd1: begin cv = -y; sv = x;  end
			2'd2: begin cv = -x; sv = -y; end
			default: begin cv = y; sv = -x; end
		endcase
	endfunction

	// Rotated, re-offset and clamped point for one input item.
	function automatic out_item_t rotate_point(input in_item_t it, input bit deg);
		longint    d [3];
		longint    o [3];
		longint    m [9];
		longint    ca, sa, cb, sb, cc, sc, sbsc, sbcc, sh, sl, v;
		out_item_t r;
		o[0] = it.origin_x; o[1] = it.origin_y; o[2] = it.origin_z;
		d[0] = longint'(it.point_x) - o[0];
		d[1] = longint'(it.point_y) - o[1];
		d[2] = longint'(it.point_z) - o[2];
		angle_trig(it.yaw_angle, deg, ca, sa);
		angle_trig(it.pitch_angle, deg, cb, sb);
		angle_trig(it.roll_angle, deg, cc, sc);
		sbsc = q30_mul(sb, sc);
		sbcc = q30_mul(sb, cc);
		m[0] = q30_mul(ca, cb);
		m[1] = q30_mul(ca, sbsc) - q30_mul(sa, cc);
		m[2] = q30_mul(ca, sbcc) + q30_mul(sa, sc);
		m[3] = q30_mul(sa, cb);
		m[4] = q30_mul(sa, sbsc) + q30_mul(ca, cc);
		m[5] = q30_mul(sa, sbcc) - q30_mul(ca, sc);
		m[6] = -sb;
		m[7] = q30_mul(cb, sc);
		m[8] = q30_mul(cb, cc);
		r.saturated = 1'b0;
		for (int k = 0; k < 3; k++) begin
			sh = 0;
			sl = 0;
			for (int j = 0; j < 3; j++) begin
				sh += m[3*k+j] * (d[j] >>> 24);
				sl += m[3*k+j] * (d[j] & 64'hFFFFFF);
			end
			sl += 64'sd1 <<< 29;
			v = ((sh + (sl >>> 24)) >>> 6) + o[k];
			if (v > longint'(CMax)) begin v = CMax; r.saturated = 1'b1; end
			if (v < longint'(CMin)) begin v = CMin; r.saturated = 1'b1; end
			case (k)
				0: r.rotated_x = coord_t'(v);
				1: r.rotated_y = coord_t'(v);
				default: r.rotated_z = coord_t'(v);
			endcase
		end
		return r;
	endfunction

	// Receiver stalls: alternating stretches of free flow and random stalls.
	int rx_cyc = 0;
	always @(posedge clk) begin
		rx_cyc <= rx_cyc + 1;
		if ((rx_cyc / 200) % 3 == 0)
			out_ch.ready <= 1'b1;
		else if ((rx_cyc / 200) % 3 == 1)
			out_ch.ready <= ($urandom_range(0, 3) != 0);
		else
			out_ch.ready <= ($urandom_range(0, 1) != 0);
	end

	// Result checker: samples the handshake mid-cycle, ahead of the edge that takes it.
	always @(negedge clk) begin
		out_item_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (rotated_q.size() == 0) begin
				$error("result with no expected item: %p", out_ch.data);
				fails++;
			end else begin
				want = rotated_q.pop_front();
				if (out_ch.data.rotated_x !== want.rotated_x) begin
					$error("rotated_x expected %0d got %0d", want.rotated_x,
						out_ch.data.rotated_x);
					fails++;
				end
				if (out_ch.data.rotated_y !== want.rotated_y) begin
					$error("rotated_y expected %0d got %0d", want.rotated_y,
						out_ch.data.rotated_y);
					fails++;
				end
				if (out_ch.data.rotated_z !== want.rotated_z) begin
					$error("rotated_z expected %0d got %0d", want.rotated_z,
						out_ch.data.rotated_z);
					fails++;
				end
				if (out_ch.data.saturated !== want.saturated) begin
					$error("saturated expected %0b got %0b", want.saturated,
						out_ch.data.saturated);
					fails++;
				end
			end
		end
	end

	// Offer one item and hold it until it is taken; returns at the accepting edge.
	task automatic send_item(input in_item_t it, input bit known, input out_item_t res);
		bit took;
		in_ch.valid <= 1'b1;
		in_ch.data  <= it;
		do begin
			@(negedge clk);
			took = in_ch.ready;
			if (took)
				rotated_q.push_back(known ? res : rotate_point(it, deg_mode));
			@(posedge clk);
		end while (!took);
	endtask

	// Sender gaps: bursts of random length, most of them followed by a random pause.
	int burst_left = 0;
	task automatic sender_gap();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 40);
			if ($urandom_range(0, 2) != 0) begin
				in_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	endtask

	// Stop sending and wait until every result is back.
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (rotated_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_unit(input bit deg);
		cfg_we    <= 1'b1;
		cfg_wdata <= deg;
		@(posedge clk);
		cfg_we    <= 1'b0;
		deg_mode  = deg;
	endtask

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 3))
			0: return coord_t'($urandom());
			1: return coord_t'($signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000);
			2: return $urandom_range(0, 1) ? CMax - $urandom_range(0, 255)
				: CMin + $urandom_range(0, 255);
			default: return coord_t'($signed($urandom_range(0, 32'h001FFFFF)) - 32'sh00100000);
		endcase
	endfunction

	function automatic coord_t rand_angle(input bit deg);
		case ($urandom_range(0, 3))
			0: return coord_t'($urandom());
			1: return deg ? coord_t'($signed($urandom_range(0, 47185920)) - 23592960)
				: coord_t'($signed($urandom_range(0, 823550)) - 411775);
			2: return coord_t'($signed($urandom_range(0, 32'h3FFF)) - 32'sh2000);
			default: return coord_t'($signed($urandom_range(0, 32'h7FFFFFF)) - 32'sh4000000);
		endcase
	endfunction

	function automatic in_item_t rand_item(input bit deg);
		in_item_t it;
		it.point_x     = rand_coord();
		it.point_y     = rand_coord();
		it.point_z     = rand_coord();
		it.origin_x    = rand_coord();
		it.origin_y    = rand_coord();
		it.origin_z    = rand_coord();
		it.pitch_angle = rand_angle(deg);
		it.yaw_angle   = rand_angle(deg);
		it.roll_angle  = rand_angle(deg);
		return it;
	endfunction

	function automatic in_item_t mk(input coord_t px, py, pz, ox, oy, oz, pa, ya, ra);
		in_item_t it;
		it = '{px, py, pz, ox, oy, oz, pa, ya, ra};
		return it;
	endfunction

	dir_row_t dir_rows[$];
	out_item_t none_res = '0;

	initial begin
		in_item_t it;
		in_ch.valid   = 1'b0;
		in_ch.data    = '0;
		out_ch.ready  = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items: point on the origin comes back unchanged.
		dir_rows.push_back('{mk(5, 6, 7, 5, 6, 7, CMax, CMin, 32'sd12345), 1'b1,
			'{32'sd5, 32'sd6, 32'sd7, 1'b0}});
		dir_rows.push_back('{mk(CMax, CMax, CMax, CMax, CMax, CMax, CMin, CMax, CMax), 1'b1,
			'{CMax, CMax, CMax, 1'b0}});
		dir_rows.push_back('{mk(CMin, CMin, CMin, CMin, CMin, CMin, CMax, 0, CMin), 1'b1,
			'{CMin, CMin, CMin, 1'b0}});
		dir_rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '{0, 0, 0, 1'b0}});
		// Predicted rows: identity, quarter, half and eighth turns, full-range spans, saturation and mixed angles.
		dir_rows.push_back('{mk(32'sh10000, 32'sh20000, 32'sh30000, 0, 0, 0, 0, 0, 0),
			1'b0, none_res});
		dir_rows.push_back('{mk(32'sh10000, 0, 0, 0, 0, 0, 0, 32'sd102944, 0), 1'b0, none_res});
		dir_rows.push_back('{mk(0, 32'sh10000, 0, 0, 0, 0, 32'sd102944, 0, 0), 1'b0, none_res});
		dir_rows.push_back('{mk(0, 0, 32'sh10000, 0, 0, 0, 0, 0, 32'sd102944), 1'b0, none_res});
		dir_rows.push_back('{mk(CMax, CMax, CMax, CMin, CMin, CMin, 0, 0, 0), 1'b0, none_res});
		dir_rows.push_back('{mk(CMin, CMin, CMin, CMax, CMax, CMax, 0, 0, 0), 1'b0, none_res});
		dir_rows.push_back('{mk(CMax, CMin, CMax, CMin, CMax, CMin, 32'sd205887, 32'sd205887,
			32'sd205887), 1'b0, none_res});
		dir_rows.push_back('{mk(32'sh7FFF0000, 0, 0, 0, 0, 0, 0, 32'sd51472, 0), 1'b0, none_res});
		dir_rows.push_back('{mk(32'sh10000, 32'sh10000, 32'sh10000, 0, 0, 0, CMax, CMin, CMax),
			1'b0, none_res});
		dir_rows.push_back('{mk(32'sh10000, 32'sh10000, 32'sh10000, 32'sh8000, 0, 0,
			-32'sd102944, -32'sd205887, 32'sd411775), 1'b0, none_res});
		dir_rows.push_back('{mk(-1, -1, -1, 1, 1, 1, -1, 1, -1), 1'b0, none_res});

		// Phase one: radians.
		write_unit(1'b0);
		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].stim, dir_rows[i].known, dir_rows[i].res);
			sender_gap();
		end
		for (int n = 0; n < 600; n++) begin
			send_item(rand_item(1'b0), 1'b0, none_res);
			sender_gap();
		end
		drain();

		// Phase two: degrees, with the same directed rows, the quarter turns restated in degrees.
		write_unit(1'b1);
		foreach (dir_rows[i]) begin
			it = dir_rows[i].stim;
			if (!dir_rows[i].known && i >= 5 && i <= 7) begin
				it.yaw_angle   = (it.yaw_angle != 0) ? 32'sh5A0000 : 0;
				it.pitch_angle = (it.pitch_angle != 0) ? 32'sh5A0000 : 0;
				it.roll_angle  = (it.roll_angle != 0) ? 32'sh5A0000 : 0;
			end
			send_item(it, dir_rows[i].known, dir_rows[i].res);
			sender_gap();
		end
		for (int n = 0; n < 650; n++) begin
			send_item(rand_item(1'b1), 1'b0, none_res);
			sender_gap();
		end
		drain();

		// Phase three: back to radians, then degrees again.
		write_unit(1'b0);
		for (int n = 0; n < 320; n++) begin
			send_item(rand_item(1'b0), 1'b0, none_res);
			sender_gap();
		end
		drain();
		write_unit(1'b1);
		for (int n = 0; n < 320; n++) begin
			send_item(rand_item(1'b1), 1'b0, none_res);
			sender_gap();
		end
		drain();

		if (fails == 0)
			$display("tb_point_rotate_3d_euler: PASS");
		else
			$display("tb_point_rotate_3d_euler: FAIL");
		$finish;
	end
endmodule
